// ----- design/imu_sample_time_interpolator_defines.svh -----
// assertion macros shared by the interpolator
`ifndef IMU_SAMPLE_TIME_INTERPOLATOR_DEFINES_SVH
`define IMU_SAMPLE_TIME_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define STI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imu interpolator check failed");

// next-cycle implication
`define STI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imu interpolator check failed");

`endif

// ----- design/imu_sti_pkg.sv -----
package imu_sti_pkg;

  localparam int STAMP_W   = 48;
  localparam int VAL_W     = 32;
  localparam int NUM_VALS  = 10;
  localparam int GAP_W     = 24;
  localparam int Q_FIRST   = 6;
  localparam int NUM_QUAT  = 4;
  localparam int DATA_W    = VAL_W * NUM_VALS;

  localparam logic [GAP_W-1:0] MAX_GAP_RESET = 24'd200000;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_SYNC = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FRONT_LATE = 3'd1,
    ST_GAP        = 3'd2,
    ST_FEW        = 3'd3,
    ST_PUSHED     = 3'd4,
    ST_DROPPED    = 3'd5
  } status_t;

  typedef logic [NUM_VALS-1:0][VAL_W-1:0] vals_t;

  typedef struct packed {
    req_t               req;
    logic [STAMP_W-1:0] stamp;
    vals_t              vals;
  } cmd_t;

endpackage

// ----- design/imu_sti_ram.sv -----
module imu_sti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/imu_sti_front.sv -----
module imu_sti_front import imu_sti_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t in_cmd,
  output logic busy,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_take
);

  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] fill;
  logic [1:0] fill_next;
  logic       accept;
  cmd_t       slots [2];

  // no beat is taken while reset is held
  assign accept    = start && !busy;
  assign busy      = rst || (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign fill_next = fill + {1'b0, accept} - {1'b0, cmd_take};

  // two-beat command queue toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill_next;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ----- design/imu_sti_back.sv -----
module imu_sti_back import imu_sti_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_take,
  input  logic [GAP_W-1:0]   max_gap,
  output logic               done,
  output status_t            res_status,
  output logic [STAMP_W-1:0] res_stamp,
  output vals_t              res_vals
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_PUSH  = 16'h0002,
    S_CHECK = 16'h0004,
    S_RD0   = 16'h0008,
    S_RD1   = 16'h0010,
    S_EVAL  = 16'h0020,
    S_DAT0  = 16'h0040,
    S_DAT1  = 16'h0080,
    S_WDIV  = 16'h0100,
    S_LERP  = 16'h0200,
    S_SQ    = 16'h0400,
    S_SQRT  = 16'h0800,
    S_NSET  = 16'h1000,
    S_NDIV  = 16'h2000,
    S_NFIN  = 16'h4000,
    S_OUT   = 16'h8000
  } state_t;

  state_t state;

  // ring pointers
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] head1;
  logic [IDX_W-1:0] tail;

  // current item
  logic [STAMP_W-1:0] cur_stamp;
  vals_t              cur_vals;

  // neighbour samples
  logic [STAMP_W-1:0] t0;
  logic [STAMP_W-1:0] t1;
  vals_t              va;
  vals_t              vb;
  logic [STAMP_W-1:0] t_rd;
  logic [DATA_W-1:0]  d_rd;
  logic               push_ok;

  // weight divider
  logic [STAMP_W-1:0] den;
  logic [STAMP_W-1:0] wrem;
  logic [16:0]        wnum;
  logic [16:0]        wq;
  logic [4:0]         cnt;

  // interpolation and norm
  logic signed [49:0] p1;
  logic signed [49:0] p2;
  logic [VAL_W-1:0]   vals [NUM_VALS];
  logic [63:0]        sq_r;
  logic [64:0]        acc;
  logic [63:0]        s_sh;
  logic [33:0]        srem;
  logic [31:0]        sroot;
  logic [32:0]        n_r;
  logic [32:0]        ndrem [NUM_QUAT];
  logic [31:0]        ndnum [NUM_QUAT];
  logic [31:0]        ndq   [NUM_QUAT];
  logic               nneg  [NUM_QUAT];

  // combinational helpers
  logic [STAMP_W-1:0] dt;
  logic [STAMP_W-1:0] dt1;
  logic [STAMP_W-1:0] den_w;
  logic               gap0;
  logic               gap1;
  logic [64:0]        wnum_full;
  logic [STAMP_W:0]   wtrial;
  logic               wge;
  logic [3:0]         li;
  logic [16:0]        wc;
  logic signed [49:0] m1;
  logic signed [49:0] m2;
  logic signed [50:0] lsum;
  logic [VAL_W-1:0]   qsel;
  logic signed [63:0] sq_w;
  logic [64:0]        acc_sum;
  logic [35:0]        srem_sh;
  logic [35:0]        strial;
  logic               sge;
  logic [32:0]        nsel;
  logic [31:0]        mag   [NUM_QUAT];
  logic [61:0]        nnum  [NUM_QUAT];
  logic [33:0]        ntrial [NUM_QUAT];
  logic [33:0]        ndiff  [NUM_QUAT];

  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign head1    = wrap_add(head, CNT_W'(1));
  assign tail     = wrap_add(head, count);
  assign push_ok  = (count != CNT_W'(QUEUE_DEPTH));
  assign cmd_take = (state == S_IDLE) && cmd_valid;

  // sample memories
  imu_sti_ram #(.WIDTH(STAMP_W), .DEPTH(QUEUE_DEPTH)) u_time_ram (
    .clk     (clk),
    .wr_en   ((state == S_PUSH) && push_ok),
    .wr_addr (tail),
    .wr_data (cur_stamp),
    .rd_addr ((state == S_RD0) ? head1 : head),
    .rd_data (t_rd)
  );

  imu_sti_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_data_ram (
    .clk     (clk),
    .wr_en   ((state == S_PUSH) && push_ok),
    .wr_addr (tail),
    .wr_data (cur_vals),
    .rd_addr ((state == S_DAT0) ? head1 : head),
    .rd_data (d_rd)
  );

  // search compares and weight divider step
  always_comb begin
    dt        = cur_stamp - t0;
    dt1       = t1 - cur_stamp;
    den_w     = t1 - t0;
    gap0      = dt > {{(STAMP_W - GAP_W){1'b0}}, max_gap};
    gap1      = dt1 > {{(STAMP_W - GAP_W){1'b0}}, max_gap};
    wnum_full = {1'b0, dt, 16'b0} + {17'b0, den_w[STAMP_W-1:1]};
    wtrial    = {wrem, wnum[16]};
    wge       = wtrial >= {1'b0, den};
  end

  // lerp multipliers and sum
  always_comb begin
    li   = cnt[3:0];
    wc   = 17'h10000 - wq;
    m1   = $signed(va[li]) * $signed({1'b0, wc});
    m2   = $signed(vb[li]) * $signed({1'b0, wq});
    lsum = $signed({p1[49], p1}) + $signed({p2[49], p2}) + 51'sd32768;
  end

  // squares and square root step
  always_comb begin
    qsel    = vals[4'(Q_FIRST) + {2'b0, cnt[1:0]}];
    sq_w    = $signed(qsel) * $signed(qsel);
    acc_sum = acc + {1'b0, sq_r};
    srem_sh = {srem, s_sh[63:62]};
    strial  = {2'b0, sroot, 2'b01};
    sge     = srem_sh >= strial;
    nsel    = acc[64] ? 33'h1_0000_0000 : {1'b0, sroot};
  end

  // normalising divider lanes
  always_comb begin
    for (int k = 0; k < NUM_QUAT; k++) begin
      mag[k]    = vals[Q_FIRST + k][31] ? (~vals[Q_FIRST + k] + 32'd1)
                                        : vals[Q_FIRST + k];
      nnum[k]   = {mag[k], 30'b0} + {30'b0, nsel[32:1]};
      ntrial[k] = {ndrem[k], ndnum[k][31]};
      ndiff[k]  = ntrial[k] - {1'b0, n_r};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_stamp <= cmd.stamp;
            cur_vals  <= cmd.vals;
            state     <= (cmd.req == REQ_PUSH) ? S_PUSH : S_CHECK;
          end
        end
        S_PUSH: begin
          done       <= 1'b1;
          res_stamp  <= '0;
          res_vals   <= '0;
          res_status <= push_ok ? ST_PUSHED : ST_DROPPED;
          if (push_ok) begin
            count <= count + CNT_W'(1);
          end
          state <= S_IDLE;
        end
        S_CHECK: begin
          if (count < CNT_W'(2)) begin
            done       <= 1'b1;
            res_stamp  <= '0;
            res_vals   <= '0;
            res_status <= ST_FEW;
            state      <= S_IDLE;
          end else begin
            state <= S_RD0;
          end
        end
        S_RD0: begin
          t0    <= t_rd;
          state <= S_RD1;
        end
        S_RD1: begin
          t1    <= t_rd;
          state <= S_EVAL;
        end
        S_EVAL: begin
          res_stamp <= '0;
          res_vals  <= '0;
          priority if (t0 > cur_stamp) begin
            done       <= 1'b1;
            res_status <= ST_FRONT_LATE;
            state      <= S_IDLE;
          end else if (t1 < cur_stamp) begin
            head  <= head1;
            count <= count - CNT_W'(1);
            state <= S_CHECK;
          end else if (gap0) begin
            head       <= head1;
            count      <= count - CNT_W'(1);
            done       <= 1'b1;
            res_status <= ST_GAP;
            state      <= S_IDLE;
          end else if (gap1) begin
            done       <= 1'b1;
            res_status <= ST_GAP;
            state      <= S_IDLE;
          end else begin
            state <= S_DAT0;
          end
        end
        S_DAT0: begin
          va    <= d_rd;
          state <= S_DAT1;
        end
        S_DAT1: begin
          vb   <= d_rd;
          den  <= den_w;
          wrem <= wnum_full[64:17];
          wnum <= wnum_full[16:0];
          wq   <= '0;
          cnt  <= '0;
          state <= (den_w == '0) ? S_LERP : S_WDIV;
        end
        S_WDIV: begin
          wrem <= wge ? STAMP_W'(wtrial - {1'b0, den}) : wtrial[STAMP_W-1:0];
          wnum <= {wnum[15:0], 1'b0};
          wq   <= {wq[15:0], wge};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            cnt   <= '0;
            state <= S_LERP;
          end
        end
        S_LERP: begin
          if (cnt < 5'(NUM_VALS)) begin
            p1 <= m1;
            p2 <= m2;
          end
          if (cnt != 5'd0) begin
            vals[li - 4'd1] <= lsum[47:16];
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(NUM_VALS)) begin
            cnt   <= '0;
            acc   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt < 5'(NUM_QUAT)) begin
            sq_r <= sq_w;
          end
          if (cnt != 5'd0) begin
            acc <= acc_sum;
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(NUM_QUAT)) begin
            cnt   <= '0;
            s_sh  <= acc_sum[63:0];
            srem  <= '0;
            sroot <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          srem  <= sge ? 34'(srem_sh - strial) : srem_sh[33:0];
          sroot <= {sroot[30:0], sge};
          s_sh  <= {s_sh[61:0], 2'b00};
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_NSET;
          end
        end
        S_NSET: begin
          cnt <= '0;
          n_r <= nsel;
          for (int k = 0; k < NUM_QUAT; k++) begin
            ndrem[k] <= {3'b0, nnum[k][61:32]};
            ndnum[k] <= nnum[k][31:0];
            ndq[k]   <= '0;
            nneg[k]  <= vals[Q_FIRST + k][31];
          end
          // zero quaternion passes unchanged
          state <= (acc == '0) ? S_OUT : S_NDIV;
        end
        S_NDIV: begin
          for (int k = 0; k < NUM_QUAT; k++) begin
            ndrem[k] <= ndiff[k][33] ? ntrial[k][32:0] : ndiff[k][32:0];
            ndnum[k] <= {ndnum[k][30:0], 1'b0};
            ndq[k]   <= {ndq[k][30:0], ~ndiff[k][33]};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_NFIN;
          end
        end
        S_NFIN: begin
          for (int k = 0; k < NUM_QUAT; k++) begin
            vals[Q_FIRST + k] <= nneg[k] ? (~ndq[k] + 32'd1) : ndq[k];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          done       <= 1'b1;
          res_status <= ST_OK;
          res_stamp  <= cur_stamp;
          for (int k = 0; k < NUM_VALS; k++) begin
            res_vals[k] <= vals[k];
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/imu_sample_time_interpolator.sv -----
// IMU sample time interpolator. A push beat (req_type 0) appends a sample, if
// there is room, to a ring of QUEUE_DEPTH entries and a sync beat (req_type 1)
// interpolates the two samples around stamp_us, renormalising the quaternion.
// Every beat gives exactly one result, shown for one cycle with done high; the
// receiver cannot stall, so it must take the result in that cycle. A two-beat
// command queue sits in front, so start is taken while the back end works;
// busy means that queue is full or reset is held. A sync drops each stale
// entry it meets on the way. A successful sync skips the weight divider when
// both samples share a time and the normalizing divider for a zero
// quaternion. The weight divider, square root and normalizing divider (four
// lanes) each resolve one bit a cycle. There is no clearing pass after reset.
// cfg_ready is always high; write max_gap_us only while no beat is outstanding.
`include "imu_sample_time_interpolator_defines.svh"

module imu_sample_time_interpolator import imu_sti_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [47:0]        stamp_us,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic signed [31:0] quat_w,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  output logic               done,
  output logic [2:0]         status,
  output logic [47:0]        out_stamp_us,
  output logic signed [31:0] out_accel_x,
  output logic signed [31:0] out_accel_y,
  output logic signed [31:0] out_accel_z,
  output logic signed [31:0] out_rate_x,
  output logic signed [31:0] out_rate_y,
  output logic signed [31:0] out_rate_z,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        max_gap_us
);

  cmd_t               in_cmd;
  cmd_t               cmd;
  logic               cmd_valid;
  logic               cmd_take;
  logic [GAP_W-1:0]   max_gap;
  status_t            res_status;
  logic [STAMP_W-1:0] res_stamp;
  vals_t              res_vals;

  // pack the input beat
  always_comb begin
    in_cmd.req     = req_t'(req_type);
    in_cmd.stamp   = stamp_us;
    in_cmd.vals[0] = accel_x;
    in_cmd.vals[1] = accel_y;
    in_cmd.vals[2] = accel_z;
    in_cmd.vals[3] = rate_x;
    in_cmd.vals[4] = rate_y;
    in_cmd.vals[5] = rate_z;
    in_cmd.vals[6] = quat_w;
    in_cmd.vals[7] = quat_x;
    in_cmd.vals[8] = quat_y;
    in_cmd.vals[9] = quat_z;
  end

  // gap register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= MAX_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_gap <= max_gap_us;
    end
  end

  imu_sti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_cmd    (in_cmd),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  imu_sti_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .max_gap    (max_gap),
    .done       (done),
    .res_status (res_status),
    .res_stamp  (res_stamp),
    .res_vals   (res_vals)
  );

  // result ports
  assign status       = res_status;
  assign out_stamp_us = res_stamp;
  assign out_accel_x  = res_vals[0];
  assign out_accel_y  = res_vals[1];
  assign out_accel_z  = res_vals[2];
  assign out_rate_x   = res_vals[3];
  assign out_rate_y   = res_vals[4];
  assign out_rate_z   = res_vals[5];
  assign out_quat_w   = res_vals[6];
  assign out_quat_x   = res_vals[7];
  assign out_quat_y   = res_vals[8];
  assign out_quat_z   = res_vals[9];

  // checks
  `STI_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  `STI_ASSERT_IMP(a_fail_zero_stamp, clk, rst, done && (status != ST_OK), out_stamp_us == '0)
  `STI_ASSERT_IMP(a_busy_has_work, clk, rst, busy, cmd_valid)

endmodule
